[sv/counting_semaphore_waiter_queues_top_defines.svh]
// Assertion macros for the counting semaphore block.
// Included by the top level; it needs no other file.
`ifndef COUNTING_SEMAPHORE_WAITER_QUEUES_TOP_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAITER_QUEUES_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define CSEM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSEM_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define CSEM_ASSERT(lbl, clk, rst, prop, msg)
`define CSEM_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

[sv/csem_pkg.sv]
// Shared constants for the counting semaphore block: opcodes, result kinds,
// count limits and register indexes. Depends on nothing.
package csem_pkg;

  localparam logic [1:0] OP_WAIT   = 2'd0;
  localparam logic [1:0] OP_SIGNAL = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] KIND_PASSED   = 3'd0;
  localparam logic [2:0] KIND_BLOCKED  = 3'd1;
  localparam logic [2:0] KIND_RELEASED = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_REJECTED = 3'd4;
  localparam logic [2:0] KIND_REPORT   = 3'd5;

  localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

  localparam logic REG_INITIAL_COUNT = 1'b0;

  localparam int ID_PORT_W = 8;

endpackage

[sv/counting_semaphore_waiter_queues_top.sv]
// Counting semaphore with an untimed and a timed FIFO waiter queue.
// Uses csem_pkg and counting_semaphore_waiter_queues_top_defines.svh.
//
//   channel  handshake            payload
//   req      req_valid/req_ready  opcode, thread_id, wait_time, signal_count
//   rsp      rsp_valid/rsp_ready  result_kind, released_thread, from_timed_queue,
//                                 released_total, count_value, last
//   cfg      APB psel/penable     paddr, pwdata, prdata, pready
//
// A wait, a count read or a rejected signal has its result registered in S_CALC.
// A signal runs S_LIMIT, S_CALC, S_FETCH, then S_EMIT and S_FETCH per released
// waiter, and S_DONE, with one 17-bit adder and registered waiter memory reads.
// Reset clears the count, queue pointers and sequencer; queue contents stay.
// Results wait in an output register; a stalled result holds the sequencer.
`include "counting_semaphore_waiter_queues_top_defines.svh"

module counting_semaphore_waiter_queues_top #(
  parameter int WAITER_DEPTH = 16,
  parameter int ID_WIDTH     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  thread_id,
  input  logic [15:0] wait_time,
  input  logic signed [15:0] signal_count,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  released_thread,
  output logic        from_timed_queue,
  output logic signed [15:0] released_total,
  output logic signed [15:0] count_value,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PTR_W   = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int FILL_W  = $clog2(WAITER_DEPTH + 1);
  localparam int SUM_W   = FILL_W + 1;
  localparam int STORE_W = (ID_WIDTH < csem_pkg::ID_PORT_W) ? ID_WIDTH
                                                            : csem_pkg::ID_PORT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_CALC,
    S_FETCH,
    S_EMIT,
    S_DONE
  } state_t;

  state_t state;

  logic [7:0]          init_count;
  logic signed [15:0]  count;
  logic [1:0]          op;
  logic [STORE_W-1:0]  tid;
  logic                timed_wait;
  logic signed [15:0]  n;
  logic [16:0]         remaining;
  logic [15:0]         released;
  logic                rel_timed;

  logic [PTR_W-1:0]    plain_head;
  logic [FILL_W-1:0]   plain_fill;
  logic [PTR_W-1:0]    timed_head;
  logic [FILL_W-1:0]   timed_fill;

  logic [STORE_W-1:0]  plain_mem [WAITER_DEPTH];
  logic [STORE_W-1:0]  timed_mem [WAITER_DEPTH];
  logic [STORE_W-1:0]  plain_rd;
  logic [STORE_W-1:0]  timed_rd;

  logic [16:0]         alu_a;
  logic [16:0]         alu_b;
  logic [16:0]         alu_sum;
  logic signed [15:0]  reps;
  logic signed [15:0]  wait_count;
  logic signed [15:0]  sig_count;
  logic                out_free;
  logic                cfg_write;
  logic                plain_we;
  logic                timed_we;
  logic                plain_has_room;
  logic                timed_has_room;
  logic [SUM_W-1:0]    plain_tail_sum;
  logic [SUM_W-1:0]    timed_tail_sum;
  logic [PTR_W-1:0]    plain_tail;
  logic [PTR_W-1:0]    timed_tail;
  logic [PTR_W-1:0]    plain_head_next;
  logic [PTR_W-1:0]    timed_head_next;
  logic                queues_empty;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == csem_pkg::REG_INITIAL_COUNT) ? {24'd0, init_count}
                                                              : 32'd0;

  assign req_ready = (state == S_IDLE) && !rst;
  assign out_free  = !rsp_valid || rsp_ready;
  assign reps      = (n == 16'sd0) ? 16'sd1 : n;

  always_comb begin
    alu_a = {count[15], count};
    alu_b = 17'h1FFFF;
    case (state)
      S_LIMIT: begin
        alu_a = ~{count[15], count};
        alu_b = 17'd1;
      end
      S_CALC: begin
        if (op == csem_pkg::OP_SIGNAL) begin
          alu_b = {1'b0, reps};
        end
      end
      S_EMIT: begin
        alu_a = remaining;
      end
      default: begin
        alu_a = {count[15], count};
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b;

  assign wait_count = (count == csem_pkg::COUNT_MIN) ? count : alu_sum[15:0];
  assign sig_count  = (alu_sum[16:15] == 2'b01) ? csem_pkg::COUNT_MAX : alu_sum[15:0];

  assign plain_has_room = (plain_fill != FILL_W'(WAITER_DEPTH));
  assign timed_has_room = (timed_fill != FILL_W'(WAITER_DEPTH));
  assign queues_empty   = (plain_fill == '0) && (timed_fill == '0);

  assign plain_tail_sum = SUM_W'(plain_head) + SUM_W'(plain_fill);
  assign timed_tail_sum = SUM_W'(timed_head) + SUM_W'(timed_fill);
  assign plain_tail = (plain_tail_sum >= SUM_W'(WAITER_DEPTH))
                      ? PTR_W'(plain_tail_sum - SUM_W'(WAITER_DEPTH))
                      : PTR_W'(plain_tail_sum);
  assign timed_tail = (timed_tail_sum >= SUM_W'(WAITER_DEPTH))
                      ? PTR_W'(timed_tail_sum - SUM_W'(WAITER_DEPTH))
                      : PTR_W'(timed_tail_sum);
  assign plain_head_next = (plain_head == PTR_W'(WAITER_DEPTH - 1)) ? '0 : plain_head + 1'b1;
  assign timed_head_next = (timed_head == PTR_W'(WAITER_DEPTH - 1)) ? '0 : timed_head + 1'b1;

  assign plain_we = (state == S_CALC) && (op == csem_pkg::OP_WAIT) && out_free &&
                    wait_count[15] && !timed_wait && plain_has_room;
  assign timed_we = (state == S_CALC) && (op == csem_pkg::OP_WAIT) && out_free &&
                    wait_count[15] && timed_wait && timed_has_room;

  always_ff @(posedge clk) begin
    if (plain_we) begin
      plain_mem[plain_tail] <= tid;
    end
    plain_rd <= plain_mem[plain_head];
  end

  always_ff @(posedge clk) begin
    if (timed_we) begin
      timed_mem[timed_tail] <= tid;
    end
    timed_rd <= timed_mem[timed_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      init_count <= 8'd0;
      count      <= 16'sd0;
      plain_head <= '0;
      plain_fill <= '0;
      timed_head <= '0;
      timed_fill <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_write && paddr[2] == csem_pkg::REG_INITIAL_COUNT) begin
        init_count <= pwdata[7:0];
        count      <= {8'd0, pwdata[7:0]};
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= opcode;
            tid        <= thread_id[STORE_W-1:0];
            timed_wait <= (wait_time != 16'd0);
            n          <= signal_count;
            if (opcode == csem_pkg::OP_SIGNAL && !signal_count[15]) begin
              state <= S_LIMIT;
            end else begin
              state <= S_CALC;
            end
          end
        end
        S_LIMIT: begin
          remaining <= alu_sum;
          released  <= 16'd0;
          state     <= S_CALC;
        end
        S_CALC: begin
          case (op)
            csem_pkg::OP_WAIT: begin
              if (out_free) begin
                count            <= wait_count;
                rsp_valid        <= 1'b1;
                result_kind      <= wait_count[15] ? csem_pkg::KIND_BLOCKED
                                                   : csem_pkg::KIND_PASSED;
                released_thread  <= 8'd0;
                from_timed_queue <= 1'b0;
                released_total   <= 16'sd0;
                count_value      <= wait_count;
                last             <= 1'b1;
                if (plain_we) begin
                  plain_fill <= plain_fill + 1'b1;
                end
                if (timed_we) begin
                  timed_fill <= timed_fill + 1'b1;
                end
                state <= S_IDLE;
              end
            end
            csem_pkg::OP_SIGNAL: begin
              if (n[15]) begin
                if (out_free) begin
                  rsp_valid        <= 1'b1;
                  result_kind      <= csem_pkg::KIND_REJECTED;
                  released_thread  <= 8'd0;
                  from_timed_queue <= 1'b0;
                  released_total   <= n;
                  count_value      <= count;
                  last             <= 1'b1;
                  state            <= S_IDLE;
                end
              end else begin
                count <= sig_count;
                if (!count[15]) begin
                  remaining <= 17'd0;
                end else if (alu_sum[16] || alu_sum == 17'd0) begin
                  remaining <= {1'b0, reps};
                end
                state <= S_FETCH;
              end
            end
            default: begin
              if (out_free) begin
                rsp_valid        <= 1'b1;
                result_kind      <= csem_pkg::KIND_REPORT;
                released_thread  <= 8'd0;
                from_timed_queue <= 1'b0;
                released_total   <= 16'sd0;
                count_value      <= count;
                last             <= 1'b1;
                state            <= S_IDLE;
              end
            end
          endcase
        end
        S_FETCH: begin
          if (remaining != 17'd0 && !queues_empty) begin
            rel_timed <= (plain_fill == '0);
            state     <= S_EMIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_valid        <= 1'b1;
            result_kind      <= csem_pkg::KIND_RELEASED;
            released_thread  <= 8'(rel_timed ? timed_rd : plain_rd);
            from_timed_queue <= rel_timed;
            released_total   <= 16'sd0;
            count_value      <= count;
            last             <= 1'b0;
            if (rel_timed) begin
              timed_head <= timed_head_next;
              timed_fill <= timed_fill - 1'b1;
            end else begin
              plain_head <= plain_head_next;
              plain_fill <= plain_fill - 1'b1;
            end
            remaining <= alu_sum;
            released  <= released + 16'd1;
            state     <= S_FETCH;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid        <= 1'b1;
            result_kind      <= csem_pkg::KIND_DONE;
            released_thread  <= 8'd0;
            from_timed_queue <= 1'b0;
            released_total   <= (n == 16'sd0) ? 16'sd0 : released;
            count_value      <= count;
            last             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CSEM_ASSERT(a_fill_bound, clk, rst,
    (plain_fill <= FILL_W'(WAITER_DEPTH)) && (timed_fill <= FILL_W'(WAITER_DEPTH)),
    "waiter queue fill exceeds its depth")
  `CSEM_ASSERT(a_release_not_last, clk, rst,
    (rsp_valid && result_kind == csem_pkg::KIND_RELEASED) |-> !last,
    "a released item was marked last")
  `CSEM_ASSERT(a_pop_nonempty, clk, rst,
    (state == S_EMIT) |-> (rel_timed ? (timed_fill != '0) : (plain_fill != '0)),
    "release from an empty waiter queue")
  `CSEM_ASSERT_NEXT(a_busy_after_accept, clk, rst, (req_valid && req_ready), !req_ready,
    "a second item was taken while one was in progress")

endmodule
